/* rtl/hhe_pkg.sv */
// Shared types and constants for the Haar HH-band LSB block embed unit.
// Holds the input and result word layouts, the command codes and the
// fixed-point widths; depends on nothing.
`default_nettype none

package hhe_pkg;

	// Pixel sample width
	localparam int PIX_W = 8;
	// HH sum S = tl - tr - bl + br, range -510..510
	localparam int S_W   = 11;
	// Magnitude of S
	localparam int SM_W  = 10;
	// Magnitude of q = round(S/16), range 0..32
	localparam int QM_W  = 6;
	// Signed q and c, range -32..33
	localparam int Q_W   = 7;
	// Correction d = 16c - S, range about -1022..1038
	localparam int D_W   = 12;
	// Quarter-unit pixel 4p +/- d, range about -1038..2058
	localparam int T_W   = 13;
	// Rounded quarter-unit magnitude, range 0..515
	localparam int R_W   = 10;

	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

	// Command codes
	typedef enum logic {
		CMD_EMBED   = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	// Input word: one 2x2 pixel block
	typedef struct packed {
		cmd_t             command;
		logic [PIX_W-1:0] pix_top_left;
		logic [PIX_W-1:0] pix_top_right;
		logic [PIX_W-1:0] pix_bottom_left;
		logic [PIX_W-1:0] pix_bottom_right;
		logic             payload_bit;
	} in_word_t;

	// Result word: new block and the recovered bit
	typedef struct packed {
		logic [PIX_W-1:0] out_top_left;
		logic [PIX_W-1:0] out_top_right;
		logic [PIX_W-1:0] out_bottom_left;
		logic [PIX_W-1:0] out_bottom_right;
		logic             recovered_bit;
	} out_word_t;

	// Coefficient unit results: d for the pixel updaters, q LSB for extraction
	typedef struct packed {
		logic [D_W-1:0] d;
		logic           q_lsb;
	} coef_t;

endpackage

`default_nettype wire

/* rtl/hhe_stream_if.sv */
// Valid/ready stream channel carrying one word of a chosen packed type.
// Depends on nothing; the word type is set where the channel is declared.
`default_nettype none

interface hhe_stream_if #(
	parameter type data_t = logic
);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* rtl/hhe_coef.sv */
// HH coefficient unit: forms S, quantises it to q = round(S/16) and the
// correction d = 16c - S for the embedded coefficient c. Uses hhe_pkg.
`default_nettype none

module hhe_coef (
	input  wire logic [hhe_pkg::PIX_W-1:0] tl,
	input  wire logic [hhe_pkg::PIX_W-1:0] tr,
	input  wire logic [hhe_pkg::PIX_W-1:0] bl,
	input  wire logic [hhe_pkg::PIX_W-1:0] br,
	input  wire logic                      bit_in,
	output hhe_pkg::coef_t                 coef
);

	logic [hhe_pkg::S_W-1:0]  s;
	logic [hhe_pkg::S_W-1:0]  s_abs;
	logic [hhe_pkg::SM_W-1:0] s_mag;
	logic [hhe_pkg::SM_W-1:0] s_rnd;
	logic [hhe_pkg::QM_W-1:0] q_mag;
	logic [hhe_pkg::Q_W-1:0]  q;
	logic [hhe_pkg::Q_W-1:0]  c;
	logic [hhe_pkg::D_W-1:0]  c_x;
	logic [hhe_pkg::D_W-1:0]  s_x;

	// HH sum in two's complement
	assign s = hhe_pkg::S_W'(tl) - hhe_pkg::S_W'(tr) - hhe_pkg::S_W'(bl) + hhe_pkg::S_W'(br);

	// Round |S|/16 half away from zero, then restore the sign
	assign s_abs = s[hhe_pkg::S_W-1] ? (~s + 1'b1) : s;
	assign s_mag = s_abs[hhe_pkg::SM_W-1:0];
	assign s_rnd = s_mag + hhe_pkg::SM_W'(8);
	assign q_mag = s_rnd[hhe_pkg::SM_W-1:4];
	assign q = s[hhe_pkg::S_W-1] ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};

	// Replace the LSB of q with the payload bit
	assign c = {q[hhe_pkg::Q_W-1:1], bit_in};

	// d = 16c - S
	assign c_x = {{(hhe_pkg::D_W-hhe_pkg::Q_W){c[hhe_pkg::Q_W-1]}}, c};
	assign s_x = {{(hhe_pkg::D_W-hhe_pkg::S_W){s[hhe_pkg::S_W-1]}}, s};
	assign coef.d     = {c_x[hhe_pkg::D_W-5:0], 4'b0000} - s_x;
	assign coef.q_lsb = q[0];

endmodule

`default_nettype wire

/* rtl/hhe_pix.sv */
// Pixel updater: adds or subtracts d/4 from one sample, rounds half away
// from zero and clamps to the pixel range. Uses hhe_pkg.
`default_nettype none

module hhe_pix (
	input  wire logic [hhe_pkg::PIX_W-1:0] pix,
	input  wire logic [hhe_pkg::D_W-1:0]   d,
	input  wire logic                      sub,
	output logic      [hhe_pkg::PIX_W-1:0] pix_new
);

	logic [hhe_pkg::T_W-1:0]   p4;
	logic [hhe_pkg::T_W-1:0]   d_x;
	logic [hhe_pkg::T_W-1:0]   t;
	logic [hhe_pkg::T_W-2:0]   t_rnd;
	logic [hhe_pkg::R_W-1:0]   r;

	// Quarter-unit value 4p +/- d
	assign p4  = {{(hhe_pkg::T_W-hhe_pkg::PIX_W-2){1'b0}}, pix, 2'b00};
	assign d_x = {{(hhe_pkg::T_W-hhe_pkg::D_W){d[hhe_pkg::D_W-1]}}, d};
	assign t   = sub ? (p4 - d_x) : (p4 + d_x);

	// Round the non-negative case; a negative value rounds to zero or below
	assign t_rnd = t[hhe_pkg::T_W-2:0] + (hhe_pkg::T_W-1)'(2);
	assign r     = t_rnd[hhe_pkg::T_W-2:2];

	// Clamp to 0..255
	always_comb begin
		priority if (t[hhe_pkg::T_W-1]) begin
			pix_new = '0;
		end else if (r > hhe_pkg::R_W'(hhe_pkg::PIX_MAX)) begin
			pix_new = hhe_pkg::PIX_MAX;
		end else begin
			pix_new = r[hhe_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/haar_hh_lsb_block_embed_unit.sv */
// Top level of the Haar HH-band LSB block embed unit: input register,
// coefficient unit, four pixel updaters and a result register.
// Uses hhe_pkg, hhe_stream_if, hhe_coef and hhe_pix.
//
//   channel   dir   word         content
//   blk_in    in    in_word_t    command, 2x2 pixel block, payload bit
//   blk_out   out   out_word_t   updated 2x2 block, recovered bit
//
// One block per cycle sustained while blk_out is ready; an accepted word
// passes through the input register and then the result register, whose
// contents are offered on blk_out.
// arst_n clears both valid flags; payload registers are not reset.
// A stalled result holds in its register and the input register keeps
// filling until both stages are full; ready falls only then.
`default_nettype none

module haar_hh_lsb_block_embed_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hhe_stream_if.sink   blk_in,
	hhe_stream_if.source blk_out
);

	logic              valid_s1;
	hhe_pkg::in_word_t word_s1;
	logic              valid_s2;
	hhe_pkg::out_word_t word_s2;

	logic              adv_s2;
	logic              adv_s1;
	hhe_pkg::coef_t    coef;
	hhe_pkg::out_word_t res;
	logic [hhe_pkg::PIX_W-1:0] new_tl;
	logic [hhe_pkg::PIX_W-1:0] new_tr;
	logic [hhe_pkg::PIX_W-1:0] new_bl;
	logic [hhe_pkg::PIX_W-1:0] new_br;

	// Stage handshakes: each stage moves when the one after can take it
	assign adv_s2       = !valid_s2 || blk_out.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign blk_in.ready = adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= blk_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && blk_in.valid) begin
			word_s1 <= blk_in.data;
		end
	end

	// Coefficient and correction
	hhe_coef u_coef (
		.tl     (word_s1.pix_top_left),
		.tr     (word_s1.pix_top_right),
		.bl     (word_s1.pix_bottom_left),
		.br     (word_s1.pix_bottom_right),
		.bit_in (word_s1.payload_bit),
		.coef   (coef)
	);

	// Diagonal pixels gain d/4, off-diagonal pixels lose it
	hhe_pix u_pix_tl (.pix(word_s1.pix_top_left),     .d(coef.d), .sub(1'b0), .pix_new(new_tl));
	hhe_pix u_pix_tr (.pix(word_s1.pix_top_right),    .d(coef.d), .sub(1'b1), .pix_new(new_tr));
	hhe_pix u_pix_bl (.pix(word_s1.pix_bottom_left),  .d(coef.d), .sub(1'b1), .pix_new(new_bl));
	hhe_pix u_pix_br (.pix(word_s1.pix_bottom_right), .d(coef.d), .sub(1'b0), .pix_new(new_br));

	// Select the result by command
	always_comb begin
		unique case (word_s1.command)
			hhe_pkg::CMD_EXTRACT: begin
				res.out_top_left     = word_s1.pix_top_left;
				res.out_top_right    = word_s1.pix_top_right;
				res.out_bottom_left  = word_s1.pix_bottom_left;
				res.out_bottom_right = word_s1.pix_bottom_right;
				res.recovered_bit    = coef.q_lsb;
			end
			default: begin
				res.out_top_left     = new_tl;
				res.out_top_right    = new_tr;
				res.out_bottom_left  = new_bl;
				res.out_bottom_right = new_br;
				res.recovered_bit    = 1'b0;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			word_s2 <= res;
		end
	end

	assign blk_out.valid = valid_s2;
	assign blk_out.data  = word_s2;

endmodule

`default_nettype wire
